### rtl/core/mbgr_pkg.sv
`default_nettype none

package mbgr_pkg;

  // Gesture state of the middle button.
  typedef enum logic [1:0] {
    ST_IDLE      = 2'd0,
    ST_UNDECIDED = 2'd1,
    ST_MIDDLE    = 2'd2,
    ST_ALT       = 2'd3
  } res_state_t;

  // Event kinds on the input channel.
  localparam logic [2:0] MODE_MID_PRESS   = 3'd0;
  localparam logic [2:0] MODE_MID_RELEASE = 3'd1;
  localparam logic [2:0] MODE_MOTION      = 3'd2;
  localparam logic [2:0] MODE_ENC_PRESS   = 3'd3;
  localparam logic [2:0] MODE_ENC_RELEASE = 3'd4;

  // Result targets.
  localparam logic [1:0] TGT_MIDDLE = 2'd0;
  localparam logic [1:0] TGT_ALT    = 2'd1;
  localparam logic [1:0] TGT_KEY    = 2'd2;

  localparam int unsigned THRESH_W   = 15;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd2;

  typedef struct packed {
    logic [1:0]  target;
    logic        pressed;
    logic [31:0] keycode;
    logic        last;
  } result_t;

  // Results produced by one input transaction, in order.
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } res_bundle_t;

endpackage

`default_nettype wire

### rtl/core/mbgr_resolve.sv
`default_nettype none

module mbgr_resolve
  import mbgr_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire logic [2:0]          mode,
  input  wire logic                motion_is_xy,
  input  wire logic signed [15:0]  motion_value,
  input  wire logic [31:0]         encoder_keycode,
  input  wire logic [THRESH_W-1:0] threshold,
  output res_bundle_t              res
);

  res_state_t  state_r, state_nxt;
  logic        alt_r, alt_nxt;
  logic        key_down_r, key_down_nxt;
  logic [31:0] held_key_r, held_key_nxt;

  logic [16:0] ext;
  logic [16:0] mag;
  logic        over;

  // Magnitude of the motion in 17 bits so that the most negative count fits.
  assign ext  = {motion_value[15], motion_value};
  assign mag  = ext[16] ? (~ext + 17'd1) : ext;
  assign over = mag >= {2'b00, threshold};

  function automatic result_t mk(input logic [1:0] tgt, input logic prs,
                                 input logic [31:0] kc, input logic lst);
    result_t r;
    r.target  = tgt;
    r.pressed = prs;
    r.keycode = kc;
    r.last    = lst;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      alt_r      <= 1'b0;
      key_down_r <= 1'b0;
      held_key_r <= 32'd0;
    end else if (accept) begin
      state_r    <= state_nxt;
      alt_r      <= alt_nxt;
      key_down_r <= key_down_nxt;
      held_key_r <= held_key_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    alt_nxt      = alt_r;
    key_down_nxt = key_down_r;
    held_key_nxt = held_key_r;
    res          = '0;
    unique case (mode)
      MODE_MID_PRESS: begin
        state_nxt = ST_UNDECIDED;
      end
      MODE_MID_RELEASE: begin
        state_nxt = ST_IDLE;
        unique case (state_r)
          ST_UNDECIDED: begin
            res.count = 2'd2;
            res.r0    = mk(TGT_MIDDLE, 1'b1, 32'd0, 1'b0);
            res.r1    = mk(TGT_MIDDLE, 1'b0, 32'd0, 1'b1);
          end
          ST_MIDDLE: begin
            res.count = 2'd1;
            res.r0    = mk(TGT_MIDDLE, 1'b0, 32'd0, 1'b1);
          end
          ST_ALT: begin
            if (alt_r) begin
              alt_nxt   = 1'b0;
              res.count = 2'd1;
              res.r0    = mk(TGT_ALT, 1'b0, 32'd0, 1'b1);
            end
          end
          default: begin
          end
        endcase
      end
      MODE_MOTION: begin
        if (state_r == ST_UNDECIDED && motion_is_xy && over) begin
          state_nxt = ST_MIDDLE;
          res.count = 2'd1;
          res.r0    = mk(TGT_MIDDLE, 1'b1, 32'd0, 1'b1);
        end
      end
      MODE_ENC_PRESS: begin
        if (state_r == ST_UNDECIDED || state_r == ST_ALT) begin
          state_nxt    = ST_ALT;
          alt_nxt      = 1'b1;
          key_down_nxt = 1'b1;
          held_key_nxt = encoder_keycode;
          if (!alt_r) begin
            res.count = 2'd2;
            res.r0    = mk(TGT_ALT, 1'b1, 32'd0, 1'b0);
            res.r1    = mk(TGT_KEY, 1'b1, encoder_keycode, 1'b1);
          end else begin
            res.count = 2'd1;
            res.r0    = mk(TGT_KEY, 1'b1, encoder_keycode, 1'b1);
          end
        end else begin
          key_down_nxt = 1'b0;
        end
      end
      MODE_ENC_RELEASE: begin
        key_down_nxt = 1'b0;
        alt_nxt      = 1'b0;
        if (key_down_r && alt_r) begin
          res.count = 2'd2;
          res.r0    = mk(TGT_KEY, 1'b0, held_key_r, 1'b0);
          res.r1    = mk(TGT_ALT, 1'b0, 32'd0, 1'b1);
        end else if (key_down_r) begin
          res.count = 2'd1;
          res.r0    = mk(TGT_KEY, 1'b0, held_key_r, 1'b1);
        end else if (alt_r) begin
          res.count = 2'd1;
          res.r0    = mk(TGT_ALT, 1'b0, 32'd0, 1'b1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/mbgr_outq.sv
`default_nettype none

module mbgr_outq
  import mbgr_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire res_bundle_t wr,
  output logic             room,
  output logic             out_valid,
  input  wire logic        out_ready,
  output result_t          out_res
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(DEPTH - 2);

  result_t          mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r, wr_ptr1;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [1:0]       push_n;
  logic             pop;

  function automatic logic [PTR_W-1:0] inc(input logic [PTR_W-1:0] p);
    return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
  endfunction

  assign push_n    = push ? wr.count : 2'd0;
  assign pop       = out_valid && out_ready;
  assign wr_ptr1   = inc(wr_ptr_r);
  assign out_valid = count_r != '0;
  assign out_res   = mem[rd_ptr_r];
  assign room      = count_r <= ROOM_MAX;
  assign count_nxt = count_r + CNT_W'(push_n) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr_r] <= wr.r0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr1] <= wr.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (pop) begin
        rd_ptr_r <= inc(rd_ptr_r);
      end
      if (push_n == 2'd1) begin
        wr_ptr_r <= wr_ptr1;
      end else if (push_n == 2'd2) begin
        wr_ptr_r <= inc(wr_ptr1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("output queue holds more results than it has entries");

  a_push_only_with_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n != 2'd0) |-> room)
    else $error("results written into a full output queue");

  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !pop) |=> count_r == $past(count_r) + CNT_W'($past(push_n)))
    else $error("queue fill level lost track of written results");

endmodule

`default_nettype wire

### rtl/core/middle_button_gesture_resolver_core.sv
// A result is registered in the output queue when its input transaction is accepted.
// One input transaction per cycle while in_ready is high; the output queue drains one result
// per cycle while out_ready is high, so a tap or Alt plus key sends its two results in turn.
// in_ready drops only while the output queue cannot take two more results.
// Reset (rst_n low, synchronous) returns the gesture to idle, Alt and key up, the
// threshold to 2 and empties the output queue.
`default_nettype none

module middle_button_gesture_resolver_core
  import mbgr_pkg::*;
#(
  parameter int unsigned OUT_DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // Input channel.
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         in_mode,
  input  wire logic               in_motion_is_xy,
  input  wire logic signed [15:0] in_motion_value,
  input  wire logic [31:0]        in_encoder_keycode,
  // Result channel.
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_target,
  output logic                    out_pressed,
  output logic [31:0]             out_keycode,
  output logic                    out_last,
  // Configuration port.
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  // The single configuration register sits at word index zero; bits [1:0] of
  // the address are the byte offset and are not decoded.
  logic [THRESH_W-1:0] threshold_r;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESH_RESET;
    end else if (cfg_wr && !paddr[2]) begin
      threshold_r <= pwdata[THRESH_W-1:0];
    end
  end

  assign prdata = paddr[2] ? 32'd0 : {{(32 - THRESH_W){1'b0}}, threshold_r};

  // A transaction is taken whenever the queue has room for the worst case of
  // two results, so no event ever has to wait on the gesture logic itself.
  logic        accept;
  logic        room;
  res_bundle_t bundle;
  result_t     head;

  assign in_ready = room;
  assign accept   = in_valid && in_ready;

  // Gesture state machine: decides the results of each event in one pass.
  mbgr_resolve u_resolve (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .mode            (in_mode),
    .motion_is_xy    (in_motion_is_xy),
    .motion_value    (in_motion_value),
    .encoder_keycode (in_encoder_keycode),
    .threshold       (threshold_r),
    .res             (bundle)
  );

  // Result queue: takes up to two results per cycle and hands them out in order.
  mbgr_outq #(
    .DEPTH (OUT_DEPTH)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .wr        (bundle),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (head)
  );

  assign out_target  = head.target;
  assign out_pressed = head.pressed;
  assign out_keycode = head.keycode;
  assign out_last    = head.last;

endmodule

`default_nettype wire
